/* sv/sfr_pkg.sv */
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

    localparam int MAX_PATTERN_DEF = 8;   // default window depth
    localparam int MAX_REPLACE     = 8;   // replacement bytes held in a register
    localparam int CMD_DEPTH       = 4;   // front-to-back command queue depth
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int LEN_W           = 4;
    localparam int CNT_W           = 3;   // result count minus one, 0..7

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH     = 3'd0,
        CFG_REPLACEMENT_LENGTH = 3'd1,
        CFG_PATTERN_BYTES      = 3'd2,
        CFG_REPLACEMENT_BYTES  = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] in_char;
        logic       char_present;
        logic       end_of_string;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_present;
        logic       out_last;
    } t_out_word;

    // One accepted word's worth of results: up to eight bytes, sent lowest first.
    typedef struct packed {
        logic [8*MAX_REPLACE-1:0] data;
        logic [CNT_W-1:0]         cnt_m1;
        logic                     present;
        logic                     last;
    } t_cmd;

endpackage

/* sv/sfr_front.sv */
// Front end: config registers, match window, and result command generation.
module sfr_front #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_accept,
    input  sfr_pkg::t_in_word             i_word,
    output logic                          o_cmd_push,
    output sfr_pkg::t_cmd                 o_cmd
);

    localparam int FW = $clog2(MAX_PATTERN + 1);

    logic [sfr_pkg::LEN_W-1:0]        r_plen_raw;
    logic [sfr_pkg::LEN_W-1:0]        r_rlen_raw;
    logic [63:0]                      r_pat;
    logic [8*sfr_pkg::MAX_REPLACE-1:0] r_repl;
    logic [7:0]                       r_win [MAX_PATTERN];
    logic [FW-1:0]                    r_fill;

    logic [7:0]                       n_win [MAX_PATTERN];
    logic [FW-1:0]                    n_fill;

    logic [7:0]                       win_a [MAX_PATTERN];
    logic [FW-1:0]                    fill_a;
    logic [FW-1:0]                    pos;
    logic [FW-1:0]                    plen;
    logic [sfr_pkg::LEN_W-1:0]        rlen;
    logic                             cmp;
    logic                             match;
    logic [sfr_pkg::LEN_W-1:0]        cnt;
    logic [8*sfr_pkg::MAX_REPLACE-1:0] win_bytes;

    always_comb begin
        if (r_plen_raw == '0) begin
            plen = FW'(1);
        end else if (r_plen_raw > sfr_pkg::LEN_W'(MAX_PATTERN)) begin
            plen = FW'(MAX_PATTERN);
        end else begin
            plen = FW'(r_plen_raw);
        end
        if (r_rlen_raw > sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACE)) begin
            rlen = sfr_pkg::LEN_W'(sfr_pkg::MAX_REPLACE);
        end else begin
            rlen = r_rlen_raw;
        end
    end

    // Append the incoming byte to the window.
    always_comb begin
        pos = (r_fill >= FW'(MAX_PATTERN)) ? '0 : r_fill;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            win_a[k] = (i_word.char_present && pos == FW'(k)) ? i_word.in_char : r_win[k];
        end
        fill_a = i_word.char_present ? FW'(pos + FW'(1)) : r_fill;
    end

    always_comb begin
        match = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (FW'(k) < plen && win_a[k] != r_pat[8*k +: 8]) begin
                match = 1'b0;
            end
        end
        cmp = i_word.char_present && (fill_a >= plen);
        win_bytes = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            win_bytes[8*k +: 8] = win_a[k];
        end
    end

    always_comb begin
        n_win  = win_a;
        n_fill = fill_a;
        o_cmd  = '0;
        cnt    = '0;
        if (cmp && match) begin
            o_cmd.data = r_repl;
            cnt        = rlen;
            n_fill     = '0;
        end else if (cmp) begin
            // Mismatch: release the oldest byte (every held byte at end of string) and advance the window.
            o_cmd.data = win_bytes;
            cnt        = i_word.end_of_string ? sfr_pkg::LEN_W'(fill_a) : sfr_pkg::LEN_W'(1);
            for (int k = 0; k < MAX_PATTERN; k++) begin
                if (k + 1 < MAX_PATTERN) begin
                    n_win[k] = win_a[k+1];
                end
            end
            n_fill = fill_a - FW'(1);
        end else begin
            o_cmd.data = win_bytes;
            cnt        = i_word.end_of_string ? sfr_pkg::LEN_W'(fill_a) : '0;
        end
        if (i_word.end_of_string) begin
            n_fill = '0;
        end
        o_cmd.present = 1'b1;
        o_cmd.last    = i_word.end_of_string;
        if (cnt == '0) begin
            // Empty end: a single marker word.
            o_cmd.data    = '0;
            o_cmd.present = 1'b0;
            o_cmd.cnt_m1  = '0;
        end else begin
            o_cmd.cnt_m1 = sfr_pkg::CNT_W'(cnt - sfr_pkg::LEN_W'(1));
        end
        o_cmd_push = i_accept && (cnt != '0 || i_word.end_of_string);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen_raw <= sfr_pkg::LEN_W'(1);
            r_rlen_raw <= '0;
            r_pat      <= '0;
            r_repl     <= '0;
            r_fill     <= '0;
        end else if (i_cfg_we) begin
            case (sfr_pkg::t_cfg_idx'(i_cfg_idx))
                sfr_pkg::CFG_PATTERN_LENGTH: begin
                    r_plen_raw <= i_cfg_data[sfr_pkg::LEN_W-1:0];
                    r_fill     <= '0;
                end
                sfr_pkg::CFG_REPLACEMENT_LENGTH: r_rlen_raw <= i_cfg_data[sfr_pkg::LEN_W-1:0];
                sfr_pkg::CFG_PATTERN_BYTES:      r_pat      <= i_cfg_data;
                sfr_pkg::CFG_REPLACEMENT_BYTES:  r_repl     <= i_cfg_data;
                default: ;
            endcase
        end else if (i_accept) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

/* sv/sfr_queue.sv */
// Command queue between the front and back ends.
module sfr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sfr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sfr_pkg::t_cmd o_cmd
);

    localparam int PW = $clog2(sfr_pkg::CMD_DEPTH);
    localparam int CW = $clog2(sfr_pkg::CMD_DEPTH + 1);

    sfr_pkg::t_cmd r_mem [sfr_pkg::CMD_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(sfr_pkg::CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* sv/sfr_back.sv */
// Back end: expands each command into result words, one per cycle unless the output is held.
module sfr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  sfr_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output sfr_pkg::t_out_word o_word
);

    sfr_pkg::t_cmd            r_cur;
    logic                     r_cur_v;
    logic [sfr_pkg::CNT_W-1:0] r_idx;
    sfr_pkg::t_out_word       r_out;
    logic                     r_out_v;

    logic                     out_adv;
    logic                     consume;
    logic                     last_byte;
    logic [7:0]               cur_byte;

    assign out_adv   = !r_out_v || i_pop;
    assign consume   = r_cur_v && out_adv;
    assign last_byte = (r_idx == r_cur.cnt_m1);
    assign o_cmd_pop = i_cmd_valid && (!r_cur_v || (consume && last_byte));
    assign cur_byte  = r_cur.data[{r_idx, 3'b000} +: 8];
    assign o_empty   = !r_out_v;
    assign o_word    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_v <= 1'b0;
            r_idx   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_cur_v <= 1'b1;
                r_idx   <= '0;
            end else if (consume) begin
                // Drop the command after its final byte, else advance.
                r_cur_v <= !last_byte;
                r_idx   <= r_idx + sfr_pkg::CNT_W'(1);
            end
            if (out_adv) begin
                r_out_v <= r_cur_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cur <= i_cmd;
        end
        if (out_adv) begin
            r_out.out_char    <= cur_byte;
            r_out.out_present <= r_cur.present;
            r_out.out_last    <= r_cur.last && last_byte;
        end
    end

endmodule

/* sv/stream_find_and_replace.sv */
// Path: command queue, back-end command register, output register (empty low).
// Throughput: one word accepted per cycle while the queue has room; the back end
// sends one result per cycle unless the output is held, and a four-entry command
// queue lets the input run ahead until it fills.
// Reset: synchronous, active low; registers take their reset values, window and
// queues are emptied.
module stream_find_and_replace #(
    parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  sfr_pkg::t_in_word              i_data,
    output logic                           empty,
    input  logic                           pop,
    output sfr_pkg::t_out_word             o_data
);

    logic          accept;
    logic          cmd_push;
    sfr_pkg::t_cmd cmd_in;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    sfr_pkg::t_cmd q_cmd;

    assign full   = q_full;
    assign accept = push && !q_full;

    sfr_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_word     (i_data),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    sfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_word      (o_data)
    );

endmodule
